// ===== rtl/quadratic_bezier_flattener_core_assert.svh =====
// Assertion macros shared by the flattener checkers.
`ifndef QUADRATIC_BEZIER_FLATTENER_CORE_ASSERT_SVH
`define QUADRATIC_BEZIER_FLATTENER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbf assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbf assertion failed");

`endif

// ===== rtl/qbf_pkg.sv =====
// Shared constants and types of the quadratic Bezier flattener.
`default_nettype none
package qbf_pkg;

  localparam int SEGMENTS_DEF   = 50;
  localparam int COORD_BITS_DEF = 12;

  typedef struct packed {
    logic first;
    logic last;
  } qbf_flags_t;

endpackage
`default_nettype wire

// ===== rtl/qbf_if.sv =====
// Valid/ready channel interfaces for curve requests and segment results.
`default_nettype none
interface qbf_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] middle_x;
  logic [COORD_BITS-1:0] middle_y;
  logic [COORD_BITS-1:0] third_x;
  logic [COORD_BITS-1:0] third_y;

  modport source (output valid, first_x, first_y, middle_x, middle_y, third_x, third_y,
                  input ready);
  modport sink   (input valid, first_x, first_y, middle_x, middle_y, third_x, third_y,
                  output ready);
endinterface

interface qbf_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] from_x;
  logic [COORD_BITS-1:0] from_y;
  logic [COORD_BITS-1:0] to_x;
  logic [COORD_BITS-1:0] to_y;
  logic                  last_segment;

  modport source (output valid, from_x, from_y, to_x, to_y, last_segment, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, last_segment, output ready);
endinterface
`default_nettype wire

// ===== rtl/quadratic_bezier_flattener_core.sv =====
// Quadratic Bezier flattener: stroke points in, line segments out.
//
// in_chan carries one curve request (three stroke points A, B, C). The block
// forms P0=(A+B)/2, P1=B, P2=(B+C)/2 and sends SEGMENTS segments on out_chan,
// each from the previous integer curve sample to the current one, the final
// one with last_segment set. A request is taken when valid and ready are high.
// A sample index generator issues one sample per cycle while out_chan does
// not stall, into a six-stage pipeline: weights, products, sums, reciprocal
// multiply, quotient check, output register. Segments then leave one per
// cycle while out_chan takes them. A request occupies the generator until its
// last sample issues, and the next request is taken in the cycle its last
// sample issues, so curves follow each other with no gap.
// Synchronous reset empties the generator and every stage. When out_chan
// stalls, the whole pipeline and the generator hold and in_chan.ready drops.
`default_nettype none
module quadratic_bezier_flattener_core
  import qbf_pkg::*;
#(
  parameter int SEGMENTS   = SEGMENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  qbf_in_if.sink   in_chan,
  qbf_out_if.source out_chan
);

  localparam int CB  = COORD_BITS;
  localparam int IW  = $clog2(SEGMENTS + 1);
  localparam int DIV = SEGMENTS * SEGMENTS;
  localparam int WW  = $clog2(DIV + 1);
  localparam int NW  = CB + WW;
  localparam int MW  = NW + 1;
  localparam int PW  = NW + MW;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << NW) / DIV);
  localparam logic [NW-1:0] DIV_N = NW'(DIV);
  localparam logic [IW-1:0] SEG_I = IW'(SEGMENTS);

  logic adv;

  // generator
  logic          busy_r;
  logic [IW-1:0] idx_r;
  logic [CB-1:0] g_p0_r [2];
  logic [CB-1:0] g_p1_r [2];
  logic [CB-1:0] g_p2_r [2];
  logic          last_issue;
  logic          in_acc;
  logic [CB:0]   sum0 [2];
  logic [CB:0]   sum2 [2];
  logic [CB-1:0] in_a [2];
  logic [CB-1:0] in_b [2];
  logic [CB-1:0] in_c [2];

  // stage 1
  logic          s1_v_r;
  qbf_flags_t    s1_f_r;
  logic [WW-1:0] s1_w0_r, s1_w1_r, s1_w2_r;
  logic [CB-1:0] s1_p0_r [2];
  logic [CB-1:0] s1_p1_r [2];
  logic [CB-1:0] s1_p2_r [2];
  logic [IW-1:0]   rem_i;
  logic [2*IW-1:0] rr, ii;
  logic [2*IW:0]   ir2;

  // stage 2
  logic          s2_v_r;
  qbf_flags_t    s2_f_r;
  logic [CB-1:0] s2_p0_r [2];
  logic [NW-1:0] s2_m0_r [2];
  logic [NW-1:0] s2_m1_r [2];
  logic [NW-1:0] s2_m2_r [2];

  // stage 3
  logic          s3_v_r;
  qbf_flags_t    s3_f_r;
  logic [CB-1:0] s3_p0_r [2];
  logic [NW-1:0] s3_num_r [2];

  // stage 4
  logic          s4_v_r;
  qbf_flags_t    s4_f_r;
  logic [CB-1:0] s4_p0_r [2];
  logic [NW-1:0] s4_num_r [2];
  logic [PW-1:0] s4_prod_r [2];

  // stage 5
  logic          s5_v_r;
  qbf_flags_t    s5_f_r;
  logic [CB-1:0] s5_p0_r [2];
  logic [NW-1:0] s5_num_r [2];
  logic [CB-1:0] s5_q_r [2];
  logic [NW-1:0] s5_qd_r [2];
  logic [CB-1:0] q_est [2];

  // output
  logic          out_v_r;
  logic          out_last_r;
  logic [CB-1:0] out_from_r [2];
  logic [CB-1:0] out_to_r [2];
  logic [CB-1:0] prev_r [2];
  logic [NW-1:0] rem5 [2];
  logic [CB-1:0] q_fin [2];

  assign adv        = !out_v_r || out_chan.ready;
  assign last_issue = (idx_r == SEG_I);
  assign in_chan.ready = adv && (!busy_r || last_issue);
  assign in_acc     = in_chan.valid && in_chan.ready;

  assign in_a[0] = in_chan.first_x;
  assign in_a[1] = in_chan.first_y;
  assign in_b[0] = in_chan.middle_x;
  assign in_b[1] = in_chan.middle_y;
  assign in_c[0] = in_chan.third_x;
  assign in_c[1] = in_chan.third_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum0[a] = (CB+1)'(in_a[a]) + (CB+1)'(in_b[a]);
      sum2[a] = (CB+1)'(in_b[a]) + (CB+1)'(in_c[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      idx_r  <= IW'(1);
    end else if (adv && busy_r) begin
      if (last_issue) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int a = 0; a < 2; a++) begin
        g_p0_r[a] <= sum0[a][CB:1];
        g_p1_r[a] <= in_b[a];
        g_p2_r[a] <= sum2[a][CB:1];
      end
    end
  end

  assign rem_i = SEG_I - idx_r;
  assign rr    = (2*IW)'(rem_i) * (2*IW)'(rem_i);
  assign ii    = (2*IW)'(idx_r) * (2*IW)'(idx_r);
  assign ir2   = {(2*IW)'(idx_r) * (2*IW)'(rem_i), 1'b0};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      q_est[a] = s4_prod_r[a][NW +: CB];
      rem5[a]  = s5_num_r[a] - s5_qd_r[a];
      q_fin[a] = s5_q_r[a] + CB'(rem5[a] >= DIV_N);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= busy_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_f_r.first <= (idx_r == IW'(1));
      s1_f_r.last  <= last_issue;
      s1_w0_r      <= WW'(rr);
      s1_w1_r      <= WW'(ir2);
      s1_w2_r      <= WW'(ii);
      s2_f_r       <= s1_f_r;
      s3_f_r       <= s2_f_r;
      s4_f_r       <= s3_f_r;
      s5_f_r       <= s4_f_r;
      for (int a = 0; a < 2; a++) begin
        s1_p0_r[a]   <= g_p0_r[a];
        s1_p1_r[a]   <= g_p1_r[a];
        s1_p2_r[a]   <= g_p2_r[a];
        s2_p0_r[a]   <= s1_p0_r[a];
        s2_m0_r[a]   <= NW'(s1_w0_r) * NW'(s1_p0_r[a]);
        s2_m1_r[a]   <= NW'(s1_w1_r) * NW'(s1_p1_r[a]);
        s2_m2_r[a]   <= NW'(s1_w2_r) * NW'(s1_p2_r[a]);
        s3_p0_r[a]   <= s2_p0_r[a];
        s3_num_r[a]  <= s2_m0_r[a] + s2_m1_r[a] + s2_m2_r[a];
        s4_p0_r[a]   <= s3_p0_r[a];
        s4_num_r[a]  <= s3_num_r[a];
        s4_prod_r[a] <= PW'(s3_num_r[a]) * PW'(RECIP);
        s5_p0_r[a]   <= s4_p0_r[a];
        s5_num_r[a]  <= s4_num_r[a];
        s5_q_r[a]    <= q_est[a];
        s5_qd_r[a]   <= NW'(q_est[a]) * DIV_N;
      end
      if (s5_v_r) begin
        out_last_r <= s5_f_r.last;
        for (int a = 0; a < 2; a++) begin
          out_from_r[a] <= s5_f_r.first ? s5_p0_r[a] : prev_r[a];
          out_to_r[a]   <= q_fin[a];
          prev_r[a]     <= q_fin[a];
        end
      end
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.from_x       = out_from_r[0];
  assign out_chan.from_y       = out_from_r[1];
  assign out_chan.to_x         = out_to_r[0];
  assign out_chan.to_y         = out_to_r[1];
  assign out_chan.last_segment = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/qbf_checker.sv =====
// Port-level checker for the flattener, bound to the top level.
`default_nettype none
`include "quadratic_bezier_flattener_core_assert.svh"
module qbf_checker
  import qbf_pkg::*;
#(
  parameter int SEGMENTS   = SEGMENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [COORD_BITS-1:0] out_from_x,
  input wire [COORD_BITS-1:0] out_from_y,
  input wire [COORD_BITS-1:0] out_to_x,
  input wire [COORD_BITS-1:0] out_to_y,
  input wire                  out_last
);

  localparam int CW = $clog2(SEGMENTS + 1);

  logic                  out_acc;
  logic                  open_r;
  logic [CW-1:0]         cnt_r;
  logic [COORD_BITS-1:0] prev_x_r;
  logic [COORD_BITS-1:0] prev_y_r;
  logic [4*COORD_BITS:0] out_bus;

  assign out_acc = out_valid && out_ready;
  assign out_bus = {out_from_x, out_from_y, out_to_x, out_to_y, out_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cnt_r  <= '0;
    end else if (out_acc) begin
      open_r <= !out_last;
      cnt_r  <= out_last ? '0 : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_x_r <= out_to_x;
      prev_y_r <= out_to_y;
    end
  end

  `QBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus))
  `QBF_ASSERT_IMP(a_chain, out_acc && open_r, out_from_x == prev_x_r && out_from_y == prev_y_r)
  `QBF_ASSERT_IMP(a_last_count, out_acc && out_last, cnt_r == CW'(SEGMENTS - 1))
  `QBF_ASSERT_IMP(a_no_overrun, out_acc && !out_last, cnt_r != CW'(SEGMENTS - 1))

endmodule

bind quadratic_bezier_flattener_core qbf_checker #(
  .SEGMENTS   (SEGMENTS),
  .COORD_BITS (COORD_BITS)
) u_qbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_from_x (out_chan.from_x),
  .out_from_y (out_chan.from_y),
  .out_to_x   (out_chan.to_x),
  .out_to_y   (out_chan.to_y),
  .out_last   (out_chan.last_segment)
);
`default_nettype wire
